// ===== rtl/brl_pkg.sv =====
package brl_pkg;

    localparam int MAX_POINTS = 64;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int TW = 20;
    localparam int PW = 26;
    localparam int RW = 25;
    localparam int NUM_W = TW + PW + 2;
    localparam int DCW = $clog2(NUM_W + 1);
    localparam int POS_MAX = 2 ** (PW - 1) - 1;
    localparam int POS_MIN = -(2 ** (PW - 1));

    localparam logic [TW-1:0] STEP_MS = TW'(50);
    localparam logic [RW-1:0] CAP_RESET = RW'(256000);
    localparam logic [RW-1:0] OPEN_RESET = RW'(384000);

    localparam logic CFG_UPPER_CAP = 1'b0;
    localparam logic CFG_OPEN_UPPER = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_RANGE,
        K_UNBLOCKED,
        K_SLOPE
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEXT,
        S_SRCH,
        S_CMP,
        S_GETR,
        S_GETL,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TW-1:0]        time_ms;
        logic signed [PW-1:0] lower;
        logic signed [PW-1:0] upper;
    } t_point;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [31:0] v);
        logic signed [PW-1:0] r;
        if (v > POS_MAX) begin
            r = PW'(POS_MAX);
        end else if (v < POS_MIN) begin
            r = PW'(POS_MIN);
        end else begin
            r = v[PW-1:0];
        end
        return r;
    endfunction

    // scale a position difference by 10 or 20 and clip
    function automatic logic signed [PW-1:0] slope(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b,
                                                   input logic dbl);
        logic signed [31:0] d;
        logic signed [31:0] m;
        d = 32'(a) - 32'(b);
        m = (d <<< 3) + (d <<< 1);
        if (dbl) begin
            m = m <<< 1;
        end
        return sat_pos(m);
    endfunction

endpackage

// ===== rtl/brl_store.sv =====
module brl_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [brl_pkg::AW-1:0]    i_waddr,
    input  brl_pkg::t_point           i_wdata,
    input  logic [brl_pkg::AW-1:0]    i_raddr,
    output brl_pkg::t_point           o_rdata
);

    brl_pkg::t_point r_mem [brl_pkg::MAX_POINTS];
    brl_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/brl_div.sv =====
module brl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [brl_pkg::NUM_W-1:0]  i_num,
    input  logic [brl_pkg::TW-1:0]     i_den,
    output logic                       o_done,
    output logic [brl_pkg::NUM_W-1:0]  o_quot
);

    logic [brl_pkg::TW:0]      r_rem;
    logic [brl_pkg::NUM_W-1:0] r_quo;
    logic [brl_pkg::TW-1:0]    r_den;
    logic [brl_pkg::DCW-1:0]   r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [brl_pkg::TW:0]      rem_sh;
    logic                      fit;

    always_comb begin
        rem_sh = {r_rem[brl_pkg::TW-1:0], r_quo[brl_pkg::NUM_W-1]};
        fit = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= brl_pkg::DCW'(brl_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == brl_pkg::DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fit ? rem_sh - {1'b0, r_den} : rem_sh;
            r_quo <= {r_quo[brl_pkg::NUM_W-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/st_boundary_range_lookup.sv =====
// Load beat: the state machine moves straight to its done state after acceptance.
// Range query: a binary search over the table points, then an interpolation of the
// upper and lower bound, each with a multiply and a division; a slope query runs two
// such evaluations. One item in flight; the shared divider sets the pace.
// Synchronous active-low reset clears the table count, status, configuration registers and handshakes.
module st_boundary_range_lookup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [brl_pkg::TW-1:0]         i_time_ms,
    input  logic signed [brl_pkg::PW-1:0]  i_lower_pos,
    input  logic signed [brl_pkg::PW-1:0]  i_upper_pos,
    input  logic                           i_start_new,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_ok,
    output logic signed [brl_pkg::PW-1:0]  o_upper_out,
    output logic signed [brl_pkg::PW-1:0]  o_lower_out,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [brl_pkg::RW-1:0]         i_cfg_data
);

    localparam int TW = brl_pkg::TW;
    localparam int PW = brl_pkg::PW;
    localparam int AW = brl_pkg::AW;
    localparam int CW = brl_pkg::CW;
    localparam int NW = brl_pkg::NUM_W;
    localparam int VW = PW + 3;

    brl_pkg::t_state r_state, n_state;

    logic [brl_pkg::RW-1:0] r_cap, r_open;
    logic [CW-1:0]          r_count;
    logic                   r_good;
    logic [TW-1:0]          r_first, r_last;

    brl_pkg::t_kind         r_kind;
    logic [TW-1:0]          r_t, r_q;
    logic [2:0]             r_need;
    logic                   r_run;
    logic [1:0]             r_pass;
    logic                   r_hp, r_hn;
    logic [CW-1:0]          r_a, r_b;
    brl_pkg::t_point        r_ptr, r_ptl;
    logic                   r_sel;
    logic signed [NW-1:0]   r_prod;
    logic signed [VW-1:0]   r_vu, r_vl;
    logic signed [PW-1:0]   r_slot_u [3];
    logic signed [PW-1:0]   r_slot_l [3];
    logic                   r_res_ok;
    logic signed [PW-1:0]   r_res_up, r_res_lo;
    logic                   r_out_valid, r_out_ok;
    logic signed [PW-1:0]   r_out_up, r_out_lo;

    logic                   accept;
    logic                   clr, reject, store;
    logic [CW-1:0]          eff_cnt;
    logic                   usable, span, hp, hn;
    logic [TW:0]            t_plus;
    logic [TW-1:0]          t_minus;
    logic [CW-1:0]          mid;
    logic [AW-1:0]          rd_addr;
    brl_pkg::t_point        rd_data;
    brl_pkg::t_point        wr_data;
    logic                   div_start, div_done;
    logic [NW-1:0]          div_quot, div_num, mag;
    logic [TW-1:0]          dt, den;
    logic signed [PW:0]     diff;
    logic signed [PW-1:0]   v_left;
    logic signed [VW-1:0]   q_signed, v_new;
    logic signed [PW-1:0]   cap_u, flr_l;
    logic                   out_free;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        clr     = i_start_new || (r_count == '0);
        eff_cnt = clr ? '0 : r_count;
        reject  = (i_upper_pos < i_lower_pos) || (eff_cnt >= CW'(brl_pkg::MAX_POINTS)) ||
                  ((eff_cnt != '0) && (i_time_ms <= r_last));
        store   = !reject;
        usable  = r_good && (r_count >= CW'(2));
        span    = (i_time_ms >= r_first) && (i_time_ms <= r_last);
        t_minus = i_time_ms - brl_pkg::STEP_MS;
        t_plus  = {1'b0, i_time_ms} + {1'b0, brl_pkg::STEP_MS};
        hp      = (i_time_ms >= brl_pkg::STEP_MS) && (t_minus >= r_first);
        hn      = t_plus <= {1'b0, r_last};
        mid     = CW'(({1'b0, r_a} + {1'b0, r_b}) >> 1);
        wr_data = '{time_ms: i_time_ms, lower: i_lower_pos, upper: i_upper_pos};
    end

    // interpolation datapath
    always_comb begin
        dt     = r_q - r_ptl.time_ms;
        den    = r_ptr.time_ms - r_ptl.time_ms;
        diff   = r_sel ? ($signed({r_ptr.lower[PW-1], r_ptr.lower}) -
                          $signed({r_ptl.lower[PW-1], r_ptl.lower}))
                       : ($signed({r_ptr.upper[PW-1], r_ptr.upper}) -
                          $signed({r_ptl.upper[PW-1], r_ptl.upper}));
        mag     = r_prod[NW-1] ? NW'(-r_prod) : NW'(r_prod);
        div_num = mag + NW'(den >> 1);
        v_left  = r_sel ? r_ptl.lower : r_ptl.upper;
        q_signed = r_prod[NW-1] ? -$signed(div_quot[VW-1:0]) : $signed(div_quot[VW-1:0]);
        v_new   = VW'(v_left) + q_signed;
        cap_u   = (r_vu > $signed({{(VW - brl_pkg::RW){1'b0}}, r_cap}))
                  ? PW'(r_cap) : r_vu[PW-1:0];
        flr_l   = r_vl[VW-1] ? '0 : r_vl[PW-1:0];
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        rd_addr   = r_a[AW-1:0];
        unique case (r_state)
            brl_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (brl_pkg::t_kind'(i_kind) == brl_pkg::K_LOAD) ? brl_pkg::S_DONE
                                                                          : brl_pkg::S_NEXT;
                end
            end
            brl_pkg::S_NEXT: begin
                n_state = (r_need != '0) ? brl_pkg::S_SRCH : brl_pkg::S_DONE;
            end
            brl_pkg::S_SRCH: begin
                if (r_a < r_b) begin
                    rd_addr = mid[AW-1:0];
                    n_state = brl_pkg::S_CMP;
                end else begin
                    n_state = brl_pkg::S_GETR;
                end
            end
            brl_pkg::S_CMP: begin
                n_state = brl_pkg::S_SRCH;
            end
            brl_pkg::S_GETR: begin
                rd_addr = AW'(r_a - 1'b1);
                n_state = (r_a == '0) ? brl_pkg::S_FIN : brl_pkg::S_GETL;
            end
            brl_pkg::S_GETL: n_state = brl_pkg::S_MUL;
            brl_pkg::S_MUL:  n_state = brl_pkg::S_DSTART;
            brl_pkg::S_DSTART: begin
                div_start = 1'b1;
                n_state   = brl_pkg::S_DIV;
            end
            brl_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = r_sel ? brl_pkg::S_FIN : brl_pkg::S_MUL;
                end
            end
            brl_pkg::S_FIN:  n_state = brl_pkg::S_NEXT;
            brl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = brl_pkg::S_IDLE;
                end
            end
            default:  n_state = brl_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == brl_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, table status and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= brl_pkg::CAP_RESET;
            r_open      <= brl_pkg::OPEN_RESET;
            r_count     <= '0;
            r_good      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    brl_pkg::CFG_UPPER_CAP:  r_cap  <= i_cfg_data;
                    brl_pkg::CFG_OPEN_UPPER: r_open <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && brl_pkg::t_kind'(i_kind) == brl_pkg::K_LOAD) begin
                r_count <= store ? eff_cnt + 1'b1 : eff_cnt;
                r_good  <= (clr || r_good) && store;
            end
            if (r_state == brl_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == brl_pkg::S_DONE && out_free) begin
            r_out_ok <= r_res_ok;
            r_out_up <= r_res_up;
            r_out_lo <= r_res_lo;
        end
        if (accept) begin
            r_kind <= brl_pkg::t_kind'(i_kind);
            r_t    <= i_time_ms;
            r_hp   <= hp;
            r_hn   <= hn;
            r_need <= '0;
            // a lookup is run only for an answerable query
            r_run  <= usable && span &&
                      (brl_pkg::t_kind'(i_kind) != brl_pkg::K_LOAD) &&
                      ((brl_pkg::t_kind'(i_kind) != brl_pkg::K_SLOPE) || hp || hn);
            r_res_ok <= 1'b0;
            r_res_up <= '0;
            r_res_lo <= '0;
            unique case (brl_pkg::t_kind'(i_kind))
                brl_pkg::K_LOAD: begin
                    r_res_ok <= store;
                    if (store) begin
                        r_last <= i_time_ms;
                        if (eff_cnt == '0) begin
                            r_first <= i_time_ms;
                        end
                    end
                end
                brl_pkg::K_RANGE: begin
                    if (usable && span) begin
                        r_need <= 3'b010;
                    end
                end
                brl_pkg::K_UNBLOCKED: begin
                    if (usable && span) begin
                        r_need <= 3'b010;
                    end else if (usable) begin
                        r_res_ok <= 1'b1;
                        r_res_up <= PW'(r_open);
                    end
                end
                brl_pkg::K_SLOPE: begin
                    if (usable && span && (hp || hn)) begin
                        r_need <= {hn, !(hp && hn), hp};
                    end
                end
                default: ;
            endcase
        end
        unique case (r_state)
            brl_pkg::S_NEXT: begin
                r_a <= '0;
                r_b <= r_count;
                if (r_need[0]) begin
                    r_pass <= 2'd0;
                    r_q    <= r_t - brl_pkg::STEP_MS;
                    r_need[0] <= 1'b0;
                end else if (r_need[1]) begin
                    r_pass <= 2'd1;
                    r_q    <= r_t;
                    r_need[1] <= 1'b0;
                end else if (r_need[2]) begin
                    r_pass <= 2'd2;
                    r_q    <= r_t + brl_pkg::STEP_MS;
                    r_need[2] <= 1'b0;
                end else if (r_run && r_kind == brl_pkg::K_SLOPE) begin
                    r_res_ok <= 1'b1;
                    if (r_hp && r_hn) begin
                        r_res_up <= brl_pkg::slope(r_slot_u[2], r_slot_u[0], 1'b0);
                        r_res_lo <= brl_pkg::slope(r_slot_l[2], r_slot_l[0], 1'b0);
                    end else if (r_hp) begin
                        r_res_up <= brl_pkg::slope(r_slot_u[1], r_slot_u[0], 1'b1);
                        r_res_lo <= brl_pkg::slope(r_slot_l[1], r_slot_l[0], 1'b1);
                    end else begin
                        r_res_up <= brl_pkg::slope(r_slot_u[2], r_slot_u[1], 1'b1);
                        r_res_lo <= brl_pkg::slope(r_slot_l[2], r_slot_l[1], 1'b1);
                    end
                end else if (r_run && r_res_ok == 1'b0 && r_kind != brl_pkg::K_LOAD &&
                             r_pass == 2'd1) begin
                    r_res_ok <= 1'b1;
                    r_res_up <= r_slot_u[1];
                    r_res_lo <= r_slot_l[1];
                end
            end
            brl_pkg::S_CMP: begin
                if (rd_data.time_ms < r_q) begin
                    r_a <= mid + 1'b1;
                end else begin
                    r_b <= mid;
                end
            end
            brl_pkg::S_GETR: begin
                r_ptr <= rd_data;
                r_vu  <= VW'(rd_data.upper);
                r_vl  <= VW'(rd_data.lower);
            end
            brl_pkg::S_GETL: begin
                r_ptl <= rd_data;
                r_sel <= 1'b0;
            end
            brl_pkg::S_MUL: begin
                r_prod <= $signed({1'b0, dt}) * diff;
            end
            brl_pkg::S_DIV: begin
                if (div_done) begin
                    if (r_sel) begin
                        r_vl <= v_new;
                    end else begin
                        r_vu  <= v_new;
                        r_sel <= 1'b1;
                    end
                end
            end
            brl_pkg::S_FIN: begin
                r_slot_u[r_pass] <= cap_u;
                r_slot_l[r_pass] <= flr_l;
            end
            default: ;
        endcase
    end

    brl_store u_store (
        .i_clk   (i_clk),
        .i_we    (accept && brl_pkg::t_kind'(i_kind) == brl_pkg::K_LOAD && store),
        .i_waddr (eff_cnt[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    brl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_upper_out = r_out_up;
    assign o_lower_out = r_out_lo;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(brl_pkg::MAX_POINTS))
        else $error("table count beyond capacity");
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && brl_pkg::t_kind'(i_kind) == brl_pkg::K_LOAD) |=>
        (r_state == brl_pkg::S_DONE))
        else $error("load beat did not finish at once");
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_good && r_count >= CW'(2)) |-> (r_last > r_first))
        else $error("usable table without increasing span");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == brl_pkg::S_DIV))
        else $error("divider finished outside its wait state");
`endif

endmodule
